// ===== rtl/mtep_pkg.sv =====
`timescale 1ns / 1ps

package mtep_pkg;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);
    localparam int QueueCw    = $clog2(QueueDepth + 1);

    localparam logic [7:0] ByteMeta   = 8'hFF;
    localparam logic [7:0] ByteSysex  = 8'hF0;
    localparam logic [7:0] ByteSysEsc = 8'hF7;
    localparam logic [7:0] MetaTempo  = 8'h51;
    localparam logic [7:0] MetaEnd    = 8'h2F;

    localparam logic [3:0] NibSystem   = 4'hF;
    localparam logic [3:0] NibNoteOff  = 4'h8;
    localparam logic [3:0] NibNoteOn   = 4'h9;
    localparam logic [3:0] NibProgram  = 4'hC;
    localparam logic [3:0] NibPressure = 4'hD;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] event_time;
        logic [6:0]  note_key;
        logic [23:0] tempo_value;
    } t_out_item;

    typedef enum logic [1:0] {
        EV_NOTE_START = 2'd0,
        EV_NOTE_END   = 2'd1,
        EV_TEMPO      = 2'd2,
        EV_TRACK_END  = 2'd3
    } t_event_kind;

    typedef enum logic [2:0] {
        BC_DATA    = 3'd0,
        BC_META    = 3'd1,
        BC_SYSEX   = 3'd2,
        BC_SYSTEM  = 3'd3,
        BC_CHANNEL = 3'd4
    } t_byte_class;

    typedef struct packed {
        t_in_item    item;
        t_byte_class cls;
        logic        two_data;
    } t_q_item;

    typedef enum logic [3:0] {
        PH_DELTA    = 4'd0,
        PH_STATUS   = 4'd1,
        PH_DATA     = 4'd2,
        PH_METATYPE = 4'd3,
        PH_LEN      = 4'd4,
        PH_SKIP     = 4'd5,
        PH_ENDED    = 4'd6
    } t_phase;

    // Program change and channel pressure carry one data byte, the rest two.
    function automatic logic two_data_bytes(input logic [7:0] status);
        return (status[7:4] != NibProgram) && (status[7:4] != NibPressure);
    endfunction

endpackage

// ===== rtl/mtep_front.sv =====
`timescale 1ns / 1ps

module mtep_front (
    input  mtep_pkg::t_in_item i_item,
    output mtep_pkg::t_q_item  o_entry
);

    mtep_pkg::t_byte_class cls;

    always_comb begin
        priority if (!i_item.data_byte[7]) begin
            cls = mtep_pkg::BC_DATA;
        end else if (i_item.data_byte == mtep_pkg::ByteMeta) begin
            cls = mtep_pkg::BC_META;
        end else if (i_item.data_byte == mtep_pkg::ByteSysex ||
                     i_item.data_byte == mtep_pkg::ByteSysEsc) begin
            cls = mtep_pkg::BC_SYSEX;
        end else if (i_item.data_byte[7:4] == mtep_pkg::NibSystem) begin
            cls = mtep_pkg::BC_SYSTEM;
        end else begin
            cls = mtep_pkg::BC_CHANNEL;
        end
    end

    assign o_entry.item     = i_item;
    assign o_entry.cls      = cls;
    assign o_entry.two_data = mtep_pkg::two_data_bytes(i_item.data_byte);

endmodule

// ===== rtl/mtep_queue.sv =====
`timescale 1ns / 1ps

module mtep_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtep_pkg::t_q_item i_push_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output mtep_pkg::t_q_item o_head
);

    mtep_pkg::t_q_item r_mem [mtep_pkg::QueueDepth];
    logic [mtep_pkg::QueueAw-1:0] r_wr_ptr;
    logic [mtep_pkg::QueueAw-1:0] r_rd_ptr;
    logic [mtep_pkg::QueueCw-1:0] r_count;
    logic do_push;
    logic do_pop;

    function automatic logic [mtep_pkg::QueueCw-1:0] QueueCountStep(input logic step);
        return {{(mtep_pkg::QueueCw-1){1'b0}}, step};
    endfunction

    assign o_full  = (r_count == mtep_pkg::QueueCw'(mtep_pkg::QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QueueCountStep(do_push) - QueueCountStep(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mtep_pkg::QueueCw'(mtep_pkg::QueueDepth))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == mtep_pkg::QueueCw'(mtep_pkg::QueueDepth))
            |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

// ===== rtl/mtep_back.sv =====
`timescale 1ns / 1ps

module mtep_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  mtep_pkg::t_q_item   i_q_head,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mtep_pkg::t_out_item o_out_data
);

    mtep_pkg::t_phase r_phase, n_phase, c_phase;
    logic [7:0]  r_rs, n_rs, c_rs;
    logic [27:0] r_delta, n_delta, c_delta;
    logic [31:0] r_time, n_time, c_time;
    logic [27:0] r_skip, n_skip, c_skip;
    logic [7:0]  r_meta, n_meta, c_meta;
    logic [7:0]  r_first, n_first, c_first;
    logic [23:0] r_tempo, n_tempo, c_tempo;
    logic [1:0]  r_left, n_left, c_left;

    logic                r_out_valid;
    mtep_pkg::t_out_item r_out;
    logic                emit;
    mtep_pkg::t_out_item ev;

    logic        ts;
    logic [7:0]  b;
    logic [27:0] len_next;
    logic [27:0] skip_dec;
    logic [27:0] delta_next;
    logic [23:0] tempo_next;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_out_ready);
    assign ts      = i_q_head.item.track_start;
    assign b       = i_q_head.item.data_byte;

    // A track start clears the parser before its own byte is parsed.
    assign c_phase = ts ? mtep_pkg::PH_DELTA : r_phase;
    assign c_rs    = ts ? 8'd0  : r_rs;
    assign c_delta = ts ? 28'd0 : r_delta;
    assign c_time  = ts ? 32'd0 : r_time;
    assign c_skip  = ts ? 28'd0 : r_skip;
    assign c_meta  = ts ? 8'd0  : r_meta;
    assign c_first = ts ? 8'd0  : r_first;
    assign c_tempo = ts ? 24'd0 : r_tempo;
    assign c_left  = ts ? 2'd0  : r_left;

    assign len_next   = {c_skip[20:0], b[6:0]};
    assign skip_dec   = c_skip - {27'd0, (c_skip != 28'd0)};
    assign delta_next = {c_delta[20:0], b[6:0]};
    assign tempo_next = {c_tempo[15:0], b};

    always_comb begin
        n_phase = c_phase;
        unique case (c_phase)
            mtep_pkg::PH_STATUS: begin
                unique case (i_q_head.cls)
                    mtep_pkg::BC_DATA: begin
                        n_phase = (c_rs != 8'd0 && mtep_pkg::two_data_bytes(c_rs))
                                ? mtep_pkg::PH_DATA : mtep_pkg::PH_DELTA;
                    end
                    mtep_pkg::BC_META:    n_phase = mtep_pkg::PH_METATYPE;
                    mtep_pkg::BC_SYSEX:   n_phase = mtep_pkg::PH_LEN;
                    mtep_pkg::BC_CHANNEL: n_phase = mtep_pkg::PH_DATA;
                    default:              n_phase = mtep_pkg::PH_DELTA;
                endcase
            end
            mtep_pkg::PH_DATA: begin
                if (c_left != 2'd2) begin
                    n_phase = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_METATYPE: begin
                n_phase = (b == mtep_pkg::MetaEnd) ? mtep_pkg::PH_ENDED : mtep_pkg::PH_LEN;
            end
            mtep_pkg::PH_LEN: begin
                if (!b[7]) begin
                    n_phase = (len_next == 28'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
                end
            end
            mtep_pkg::PH_SKIP: begin
                if (skip_dec == 28'd0) begin
                    n_phase = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_ENDED: begin
                n_phase = mtep_pkg::PH_ENDED;
            end
            default: begin
                n_phase = b[7] ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
            end
        endcase
    end

    always_comb begin
        n_rs    = c_rs;
        n_delta = c_delta;
        n_time  = c_time;
        n_skip  = c_skip;
        n_meta  = c_meta;
        n_first = c_first;
        n_tempo = c_tempo;
        n_left  = c_left;
        emit    = 1'b0;
        ev.event_kind  = mtep_pkg::EV_NOTE_START;
        ev.event_time  = c_time;
        ev.note_key    = c_first[6:0];
        ev.tempo_value = 24'd0;
        unique case (c_phase)
            mtep_pkg::PH_STATUS: begin
                unique case (i_q_head.cls)
                    mtep_pkg::BC_DATA: begin
                        if (c_rs != 8'd0) begin
                            if (mtep_pkg::two_data_bytes(c_rs)) begin
                                n_first = b;
                                n_left  = 2'd1;
                            end else begin
                                n_first = 8'd0;
                                n_left  = 2'd0;
                            end
                        end
                    end
                    mtep_pkg::BC_META: begin
                        n_rs = 8'd0;
                    end
                    mtep_pkg::BC_SYSEX: begin
                        n_rs   = 8'd0;
                        n_meta = 8'd0;
                        n_skip = 28'd0;
                    end
                    mtep_pkg::BC_CHANNEL: begin
                        n_rs    = b;
                        n_first = 8'd0;
                        n_left  = i_q_head.two_data ? 2'd2 : 2'd1;
                    end
                    default: begin
                        n_rs = 8'd0;
                    end
                endcase
            end
            mtep_pkg::PH_DATA: begin
                if (c_left == 2'd2) begin
                    n_first = b;
                    n_left  = 2'd1;
                end else begin
                    n_left = 2'd0;
                    if (c_rs[7:4] == mtep_pkg::NibNoteOff) begin
                        emit          = 1'b1;
                        ev.event_kind = mtep_pkg::EV_NOTE_END;
                    end else if (c_rs[7:4] == mtep_pkg::NibNoteOn) begin
                        emit          = 1'b1;
                        ev.event_kind = (b == 8'd0) ? mtep_pkg::EV_NOTE_END
                                                    : mtep_pkg::EV_NOTE_START;
                    end
                end
            end
            mtep_pkg::PH_METATYPE: begin
                n_meta = b;
                if (b == mtep_pkg::MetaEnd) begin
                    emit          = 1'b1;
                    ev.event_kind = mtep_pkg::EV_TRACK_END;
                    ev.note_key   = 7'd0;
                end else begin
                    n_skip = 28'd0;
                end
            end
            mtep_pkg::PH_LEN: begin
                n_skip = len_next;
                if (!b[7]) begin
                    n_tempo = 24'd0;
                end
            end
            mtep_pkg::PH_SKIP: begin
                n_skip = skip_dec;
                if (c_meta == mtep_pkg::MetaTempo) begin
                    n_tempo = tempo_next;
                    if (skip_dec == 28'd0) begin
                        emit           = 1'b1;
                        ev.event_kind  = mtep_pkg::EV_TEMPO;
                        ev.note_key    = 7'd0;
                        ev.tempo_value = tempo_next;
                    end
                end
            end
            mtep_pkg::PH_ENDED: begin
                n_left = c_left;
            end
            default: begin
                if (b[7]) begin
                    n_delta = delta_next;
                end else begin
                    n_time  = c_time + {4'd0, delta_next};
                    n_delta = 28'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mtep_pkg::PH_DELTA;
            r_rs    <= '0;
            r_delta <= '0;
            r_time  <= '0;
            r_skip  <= '0;
            r_meta  <= '0;
            r_first <= '0;
            r_tempo <= '0;
            r_left  <= '0;
        end else if (o_q_pop) begin
            r_phase <= n_phase;
            r_rs    <= n_rs;
            r_delta <= n_delta;
            r_time  <= n_time;
            r_skip  <= n_skip;
            r_meta  <= n_meta;
            r_first <= n_first;
            r_tempo <= n_tempo;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && emit) begin
            r_out <= ev;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pop_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (!r_out_valid || i_out_ready))
        else $error("byte taken while the result register is blocked");

    a_ended_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mtep_pkg::PH_ENDED && !(o_q_pop && ts))
            |=> (r_phase == mtep_pkg::PH_ENDED))
        else $error("parser left the ended phase without a track start");

    a_data_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mtep_pkg::PH_DATA) |-> (r_left != 2'd0 && r_rs != 8'd0))
        else $error("data phase with no data byte due");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mtep_pkg::PH_SKIP) |-> (r_skip != 28'd0))
        else $error("skip phase with nothing left to skip");

endmodule

// ===== rtl/midi_track_event_parser_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Beat                     Handshake
// in       input      t_in_item  (byte, start) i_in_valid / o_in_ready
// out      output     t_out_item (one event)   o_out_valid / i_out_ready
//
// One track byte per cycle is taken in steady state while the queue is not full; each byte is one state update.
// An accepted byte is written into the queue; any event it yields is registered when the parser pops it.
// A four-entry queue sits between the byte classifier and the parser.
// The parser only advances when the result register is empty or being taken.
// Reset is synchronous, active low, and clears the queue and parser state.
module midi_track_event_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mtep_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mtep_pkg::t_out_item o_out_data
);

    mtep_pkg::t_q_item push_entry;
    mtep_pkg::t_q_item head;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    assign o_in_ready = !q_full;

    mtep_front u_front (
        .i_item  (i_in_data),
        .o_entry (push_entry)
    );

    mtep_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_in_valid),
        .i_push_entry (push_entry),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_valid      (q_valid),
        .o_head       (head)
    );

    mtep_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/tb_midi_track_event_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_midi_track_event_parser_unit;
    import mtep_pkg::*;

    localparam int TotalBeats    = 1880;
    localparam int LongHold      = 400;
    localparam int WatchdogLimit = 4000;
    localparam int TailCycles    = 16;
    localparam logic [7:0] MetaText = 8'h01;

    typedef struct {
        t_in_item  beat;
        logic      typed;
        t_out_item want;
    } t_script_row;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_beat   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_event;

    // Parser shadow state.
    t_phase      parse_state = PH_DELTA;
    logic [7:0]  run_status  = '0;
    logic [27:0] delta_acc   = '0;
    logic [31:0] track_clock = '0;
    logic [27:0] skip_left   = '0;
    logic [7:0]  cur_meta    = '0;
    logic [7:0]  held_key    = '0;
    logic [23:0] tempo_acc   = '0;
    logic [1:0]  data_due    = '0;

    t_out_item   pending_events[$];
    t_out_item   oldest_event;
    t_script_row directed_rows[$];

    int   mismatch_count = 0;
    int   beats_sent     = 0;
    int   quiet_cycles   = 0;
    int   rx_stall       = 0;
    int   rx_cycles      = 0;
    logic rx_steady      = 1'b0;
    logic rx_open        = 1'b0;
    logic hold_request   = 1'b0;
    logic tx_steady      = 1'b0;
    logic start_next     = 1'b0;
    logic [7:0] gen_status = '0;

    midi_track_event_parser_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_event)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_parser();
        parse_state = PH_DELTA;
        run_status  = '0;
        delta_acc   = '0;
        track_clock = '0;
        skip_left   = '0;
        cur_meta    = '0;
        held_key    = '0;
        tempo_acc   = '0;
        data_due    = '0;
    endfunction

    function automatic t_out_item make_event(input t_event_kind kind, input logic [6:0] key,
                                             input logic [23:0] tempo);
        t_out_item ev;
        ev.event_kind  = kind;
        ev.event_time  = track_clock;
        ev.note_key    = key;
        ev.tempo_value = tempo;
        return ev;
    endfunction

    function automatic logic [1:0] data_bytes_for(input logic [7:0] status);
        if (status[7:4] == NibProgram || status[7:4] == NibPressure) return 2'd1;
        return 2'd2;
    endfunction

    // One data byte of a channel message; a note event follows the last one of a note-on or note-off.
    function automatic logic take_channel_data(input logic [7:0] b, output t_out_item ev);
        ev = '0;
        if (data_due == 2'd2) begin
            held_key = b;
            data_due = 2'd1;
            return 1'b0;
        end
        data_due    = 2'd0;
        parse_state = PH_DELTA;
        if (run_status[7:4] == NibNoteOff) begin
            ev = make_event(EV_NOTE_END, held_key[6:0], '0);
            return 1'b1;
        end
        if (run_status[7:4] == NibNoteOn) begin
            ev = make_event((b == 8'd0) ? EV_NOTE_END : EV_NOTE_START, held_key[6:0], '0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic decode_track_byte(input t_in_item beat, output t_out_item ev);
        logic [7:0] b;
        logic       fired;
        b     = beat.data_byte;
        fired = 1'b0;
        ev    = '0;
        if (beat.track_start) clear_parser();
        case (parse_state)
            PH_STATUS: begin
                if (!b[7]) begin
                    if (run_status == 8'd0) begin
                        parse_state = PH_DELTA;
                    end else begin
                        held_key    = '0;
                        data_due    = data_bytes_for(run_status);
                        parse_state = PH_DATA;
                        fired       = take_channel_data(b, ev);
                    end
                end else if (b == ByteMeta) begin
                    run_status  = '0;
                    parse_state = PH_METATYPE;
                end else if (b == ByteSysex || b == ByteSysEsc) begin
                    run_status  = '0;
                    cur_meta    = '0;
                    skip_left   = '0;
                    parse_state = PH_LEN;
                end else if (b[7:4] == NibSystem) begin
                    run_status  = '0;
                    parse_state = PH_DELTA;
                end else begin
                    run_status  = b;
                    held_key    = '0;
                    data_due    = data_bytes_for(b);
                    parse_state = PH_DATA;
                end
            end
            PH_DATA: fired = take_channel_data(b, ev);
            PH_METATYPE: begin
                cur_meta = b;
                if (b == MetaEnd) begin
                    parse_state = PH_ENDED;
                    ev          = make_event(EV_TRACK_END, '0, '0);
                    fired       = 1'b1;
                end else begin
                    skip_left   = '0;
                    parse_state = PH_LEN;
                end
            end
            PH_LEN: begin
                skip_left = {skip_left[20:0], b[6:0]};
                if (!b[7]) begin
                    tempo_acc   = '0;
                    parse_state = (skip_left == 28'd0) ? PH_DELTA : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (cur_meta == MetaTempo) tempo_acc = {tempo_acc[15:0], b};
                if (skip_left != 28'd0) skip_left = skip_left - 28'd1;
                if (skip_left == 28'd0) begin
                    parse_state = PH_DELTA;
                    if (cur_meta == MetaTempo) begin
                        ev    = make_event(EV_TEMPO, '0, tempo_acc);
                        fired = 1'b1;
                    end
                end
            end
            PH_ENDED: ;
            default: begin
                delta_acc = {delta_acc[20:0], b[6:0]};
                if (!b[7]) begin
                    track_clock = track_clock + {4'd0, delta_acc};
                    delta_acc   = '0;
                    parse_state = PH_STATUS;
                end else begin
                    parse_state = PH_DELTA;
                end
            end
        endcase
        return fired;
    endfunction

    function automatic int pick_idle(input logic steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 25);
    endfunction

    function automatic logic [7:0] data_value();
        if ($urandom_range(99) < 85) return 8'($urandom_range(127));
        return 8'($urandom_range(255, 128));
    endfunction

    task automatic plain_row(input logic [7:0] b, input logic start);
        t_script_row row;
        row.beat.data_byte   = b;
        row.beat.track_start = start;
        row.typed            = 1'b0;
        row.want             = '0;
        directed_rows.push_back(row);
    endtask

    task automatic event_row(input logic [7:0] b, input t_event_kind kind, input logic [31:0] at,
                             input logic [6:0] key, input logic [23:0] tempo);
        t_script_row row;
        row.beat.data_byte    = b;
        row.beat.track_start  = 1'b0;
        row.typed             = 1'b1;
        row.want.event_kind   = kind;
        row.want.event_time   = at;
        row.want.note_key     = key;
        row.want.tempo_value  = tempo;
        directed_rows.push_back(row);
    endtask

    // Offers one beat, holds it until taken, then records what it should produce.
    task automatic send_beat(input t_in_item beat, input logic typed, input t_out_item want);
        int        gap;
        logic      fired;
        t_out_item ev;
        gap = pick_idle(tx_steady);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
        fired = decode_track_byte(beat, ev);
        if (typed) pending_events.push_back(want);
        else if (fired) pending_events.push_back(ev);
    endtask

    task automatic send_track_byte(input logic [7:0] b);
        t_in_item beat;
        beat.data_byte   = b;
        beat.track_start = start_next;
        start_next       = 1'b0;
        send_beat(beat, 1'b0, '0);
    endtask

    // Variable-length quantity, optionally led by extra continuation bytes.
    task automatic send_quantity(input logic [27:0] value, input int pad, input logic junk);
        logic [6:0] groups[4];
        int         n;
        int         i;
        n = 1;
        for (i = 0; i < 4; i++) groups[i] = value[7*i +: 7];
        for (i = 1; i < 4; i++) if ((value >> (7 * i)) != 28'd0) n = i + 1;
        repeat (pad) send_track_byte({1'b1, junk ? 7'($urandom_range(127)) : 7'd0});
        for (i = n - 1; i >= 0; i--) send_track_byte({i != 0, groups[i]});
    endtask

    task automatic send_delta();
        int r;
        r = $urandom_range(99);
        if (r < 50) send_quantity(28'($urandom_range(127)), 0, 1'b0);
        else if (r < 75) send_quantity(28'($urandom_range(16383)), 0, 1'b0);
        else if (r < 85) send_quantity(28'($urandom), 0, 1'b0);
        else if (r < 90) send_quantity(28'h0FFF_FFFF, 0, 1'b0);
        else if (r < 95) send_quantity(28'($urandom_range(127)), $urandom_range(2, 1), 1'b0);
        else send_quantity(28'($urandom), $urandom_range(2, 1), 1'b1);
    endtask

    task automatic send_channel_message();
        logic [7:0] status;
        logic [3:0] nib;
        int         r;
        r = $urandom_range(99);
        if (r < 55) nib = NibNoteOn;
        else if (r < 75) nib = NibNoteOff;
        else nib = 4'($urandom_range(14, 10));
        if (gen_status != 8'd0 && $urandom_range(2) != 0) begin
            status = gen_status;
        end else begin
            status     = {nib, 4'($urandom_range(15))};
            gen_status = status;
            send_track_byte(status);
        end
        send_track_byte(data_value());
        if (data_bytes_for(status) == 2'd2)
            send_track_byte(($urandom_range(4) == 0) ? 8'd0 : data_value());
    endtask

    task automatic send_skipped_block(input logic [7:0] lead, input logic [7:0] kind, input int len);
        send_track_byte(lead);
        if (lead == ByteMeta) send_track_byte(kind);
        send_quantity(28'(len), ($urandom_range(9) == 0) ? 1 : 0, 1'b0);
        repeat (len) send_track_byte(8'($urandom_range(255)));
        gen_status = '0;
    endtask

    // Enough maximal deltas in one track to carry the tick time past 2^32.
    task automatic run_long_track();
        start_next = 1'b1;
        gen_status = '0;
        repeat (20) begin
            send_quantity(28'h0FFF_FFFF, 0, 1'b0);
            send_track_byte({NibNoteOn, 4'($urandom_range(15))});
            send_track_byte(8'($urandom_range(127)));
            send_track_byte(8'($urandom_range(127, 1)));
        end
    endtask

    task automatic emit_random_event();
        int         pick;
        logic [7:0] status;
        logic [7:0] kind_byte;
        pick = $urandom_range(99);
        send_delta();
        if (pick < 50) begin
            send_channel_message();
        end else if (pick < 62) begin
            send_skipped_block(ByteMeta, MetaTempo,
                               ($urandom_range(9) < 7) ? 3 : $urandom_range(5));
        end else if (pick < 70) begin
            kind_byte = 8'($urandom_range(255));
            if (kind_byte == MetaEnd || kind_byte == MetaTempo) kind_byte = MetaText;
            send_skipped_block(ByteMeta, kind_byte, $urandom_range(6));
        end else if (pick < 78) begin
            send_skipped_block($urandom_range(1) ? ByteSysex : ByteSysEsc, '0, $urandom_range(6));
        end else if (pick < 83) begin
            do status = {NibSystem, 4'($urandom_range(14, 1))}; while (status == ByteSysEsc);
            send_track_byte(status);
            gen_status = '0;
        end else if (pick < 87) begin
            if (gen_status == 8'd0) send_track_byte(8'($urandom_range(127)));
            else send_channel_message();
        end else if (pick < 94) begin
            // Garbage, possibly led by a track start, then a fresh track.
            start_next = 1'($urandom_range(1));
            repeat ($urandom_range(5, 1)) send_track_byte(8'($urandom_range(255)));
            start_next = 1'b1;
            gen_status = '0;
        end else begin
            send_track_byte(ByteMeta);
            send_track_byte(MetaEnd);
            repeat ($urandom_range(3)) send_track_byte(8'($urandom_range(255)));
            start_next = 1'b1;
            gen_status = '0;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: kind %0d time %0d key %0d tempo %0d",
                       out_event.event_kind, out_event.event_time, out_event.note_key,
                       out_event.tempo_value);
                mismatch_count++;
            end else begin
                oldest_event = pending_events.pop_front();
                if (out_event.event_kind !== oldest_event.event_kind) begin
                    $error("event_kind: expected %0d, got %0d",
                           oldest_event.event_kind, out_event.event_kind);
                    mismatch_count++;
                end
                if (out_event.event_time !== oldest_event.event_time) begin
                    $error("event_time: expected %0d, got %0d",
                           oldest_event.event_time, out_event.event_time);
                    mismatch_count++;
                end
                if (out_event.note_key !== oldest_event.note_key) begin
                    $error("note_key: expected %0d, got %0d",
                           oldest_event.note_key, out_event.note_key);
                    mismatch_count++;
                end
                if (out_event.tempo_value !== oldest_event.tempo_value) begin
                    $error("tempo_value: expected %0h, got %0h",
                           oldest_event.tempo_value, out_event.tempo_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_open) begin
            out_ready <= 1'b1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            rx_stall     = LongHold;
            out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            out_ready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles % 250 == 0) rx_steady = ($urandom_range(2) == 0);
            rx_stall = pick_idle(rx_steady);
            out_ready <= (rx_stall == 0);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int   next_segment;
        int   next_drain;
        logic hold_done;
        next_segment = 150;
        next_drain   = 900;
        hold_done    = 1'b0;
        clear_parser();

        plain_row(8'h00, 1'b1);
        plain_row({NibNoteOn, 4'h0}, 1'b0);
        plain_row(8'h7F, 1'b0);
        event_row(8'h7F, EV_NOTE_START, 32'd0, 7'd127, '0);
        plain_row(8'h81, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'h00, 1'b0);
        event_row(8'h00, EV_NOTE_END, 32'd128, 7'd0, '0);
        plain_row(8'h7F, 1'b0);
        plain_row({NibNoteOff, 4'h0}, 1'b0);
        plain_row(8'hC5, 1'b0);
        event_row(8'h40, EV_NOTE_END, 32'd255, 7'h45, '0);
        plain_row(8'h00, 1'b0);
        plain_row(ByteMeta, 1'b0);
        plain_row(MetaTempo, 1'b0);
        plain_row(8'h03, 1'b0);
        plain_row(8'h07, 1'b0);
        plain_row(8'hA1, 1'b0);
        event_row(8'h20, EV_TEMPO, 32'd255, 7'd0, 24'h07A120);
        plain_row(8'h00, 1'b0);
        plain_row(ByteSysex, 1'b0);
        plain_row(8'h01, 1'b0);
        plain_row(ByteSysEsc, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row({NibSystem, 4'h8}, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(8'h40, 1'b0);
        plain_row(8'h00, 1'b0);
        plain_row(ByteMeta, 1'b0);
        event_row(MetaEnd, EV_TRACK_END, 32'd255, 7'd0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        run_long_track();
        while (beats_sent < TotalBeats) begin
            if (beats_sent >= next_segment) begin
                next_segment += 150;
                tx_steady = ($urandom_range(3) == 0);
            end
            if (!hold_done && beats_sent >= 500) begin
                // Keep offering beats while the receiver sits idle so the block backs up.
                hold_done    = 1'b1;
                hold_request = 1'b1;
                tx_steady    = 1'b1;
                next_segment = beats_sent + 120;
            end
            if (beats_sent >= next_drain) begin
                next_drain += 500;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_events.size() != 0) @(posedge clk);
            end
            emit_random_event();
        end

        in_valid <= 1'b0;
        rx_open = 1'b1;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);
        if (mismatch_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
